@@ hdl/lislt_pkg.sv @@
// Package for the LIS length tracker: sizes, key type, memory request and result structs.
// No dependencies; imported by every module of the block.
package lislt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int IN_W        = 32;
  localparam int LEN_W       = 11;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef logic [VALUE_WIDTH-1:0] key_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ovf;
  } res_t;

  // Flip the sign bit so that an unsigned compare orders keys as signed values.
  function automatic key_t to_key(input logic signed [IN_W-1:0] v);
    logic signed [VALUE_WIDTH-1:0] sx;
    sx = VALUE_WIDTH'(v);
    return {~sx[VALUE_WIDTH-1], sx[VALUE_WIDTH-2:0]};
  endfunction

endpackage

@@ hdl/lis_length_tracker.sv @@
// Top level of the LIS length tracker: handshakes, output register, instances.
// Depends on lislt_pkg, lislt_ctrl and lislt_tail_mem.
//
// Streaming longest-strictly-increasing-subsequence length by patience sorting. Each input
// word carries a signed value and a start flag; start clears the table before the value is
// used. Every input word yields exactly one output word with the current length and an
// overflow flag, set when an extending value met a full table and was dropped. The tail table
// sits in a synchronous memory with registered read data; the last tail is also held in a
// register, so an extending value costs no read. An extending (or dropped) value is accepted
// and then handed off as a result. A replacing value first runs a binary search, one memory
// read per cycle, over a table of up to 1024 entries (a single entry is overwritten at once).
// One word is worked on at a time; a finished result waits in the output register while the
// next word is accepted. There is no clearing pass after reset: only entries below the run
// count are ever read.
module lis_length_tracker
  import lislt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  value,
  input  logic                    start_req,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LEN_W-1:0]        lis_length,
  output logic                    overflow
);

  mem_req_t req;
  key_t     rdata;
  logic     busy;
  logic     res_load;
  res_t     res;
  logic     in_fire;
  logic     out_free;

  // Hold input while a word is in flight.
  assign in_stall = busy;
  assign in_fire  = in_valid && !in_stall;

  // The output register can take a new word when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;

  lislt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .value    (value),
    .start_req(start_req),
    .out_free (out_free),
    .rdata    (rdata),
    .req      (req),
    .busy     (busy),
    .res_load (res_load),
    .res      (res)
  );

  lislt_tail_mem u_mem (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  // Output register: load a finished result, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      lis_length <= res.len;
      overflow   <= res.ovf;
    end
  end

endmodule

@@ hdl/lislt_tail_mem.sv @@
// Tail table storage: one write port, one read port with registered read data.
// Depends on lislt_pkg.
module lislt_tail_mem
  import lislt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output key_t     rdata
);

  key_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ hdl/lislt_ctrl.sv @@
// Sequencer: extend check, binary search over the tail table, write-back, run count.
// Depends on lislt_pkg; drives lislt_tail_mem.
module lislt_ctrl
  import lislt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_fire,
  input  logic signed [IN_W-1:0] value,
  input  logic                   start_req,
  input  logic                   out_free,
  input  key_t                   rdata,
  output mem_req_t               req,
  output logic                   busy,
  output logic                   res_load,
  output res_t                   res
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DONE} state_t;

  state_t state;
  cnt_t   run_count;
  key_t   last_tail;
  key_t   key;
  addr_t  lo, hi, mid;
  logic   ovf;

  key_t  key_in;
  cnt_t  count_eff;
  logic  extend, full;
  addr_t hi_init, mid_init;
  logic  lt;
  addr_t lo_next, hi_next, mid_next;

  always_comb begin
    key_in    = to_key(value);
    count_eff = start_req ? '0 : run_count;
    extend    = (count_eff == '0) || (key_in > last_tail);
    full      = (count_eff == CNT_W'(TABLE_DEPTH));
    hi_init   = ADDR_W'(count_eff - cnt_t'(1));
    mid_init  = hi_init >> 1;

    lt       = (rdata < key);
    lo_next  = lt ? addr_t'(mid + addr_t'(1)) : lo;
    hi_next  = lt ? hi : mid;
    mid_next = addr_t'(lo_next + ((hi_next - lo_next) >> 1));

    req = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (extend && !full) begin
            req.we    = 1'b1;
            req.waddr = ADDR_W'(count_eff);
            req.wdata = key_in;
          end else if (!extend && hi_init != '0) begin
            req.re    = 1'b1;
            req.raddr = mid_init;
          end else if (!extend) begin
            req.we    = 1'b1;
            req.waddr = '0;
            req.wdata = key_in;
          end
        end
      end
      S_READ: begin
        if (lo_next != hi_next) begin
          req.re    = 1'b1;
          req.raddr = mid_next;
        end else begin
          req.we    = 1'b1;
          req.waddr = lo_next;
          req.wdata = key;
        end
      end
      S_DONE: ;
      default: ;
    endcase

    busy     = (state != S_IDLE);
    res_load = (state == S_DONE) && out_free;
    res.len  = LEN_W'(run_count);
    res.ovf  = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      run_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            key <= key_in;
            ovf <= extend && full;
            if (extend && !full) begin
              run_count <= cnt_t'(count_eff + cnt_t'(1));
              last_tail <= key_in;
              state     <= S_DONE;
            end else if (extend) begin
              run_count <= count_eff;
              state     <= S_DONE;
            end else if (hi_init != '0) begin
              run_count <= count_eff;
              lo        <= '0;
              hi        <= hi_init;
              mid       <= mid_init;
              state     <= S_READ;
            end else begin
              run_count <= count_eff;
              last_tail <= key_in;
              state     <= S_DONE;
            end
          end
        end
        S_READ: begin
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= mid_next;
          if (lo_next == hi_next) begin
            if (lo_next == ADDR_W'(run_count - cnt_t'(1))) begin
              last_tail <= key;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
